// ----- design/mpoc_pkg.sv -----
// shared constants and types for the multi-pattern occurrence counter
package mpoc_pkg;

  localparam int NumPatternsDef   = 4;
  localparam int MaxPatternLenDef = 8;
  localparam int CountBitsDef     = 32;
  localparam int LineBitsDef      = 24;

  localparam logic [7:0] NewlineChar = 8'h0A;

  localparam logic [1:0] ModeText  = 2'd0;
  localparam logic [1:0] ModeEof   = 2'd1;
  localparam logic [1:0] ModeClear = 2'd2;

  localparam logic KindMatch = 1'b0;
  localparam logic KindCount = 1'b1;

  localparam logic [2:0] CfgPatternZero = 3'd0;
  localparam logic [2:0] CfgPatternOne  = 3'd1;
  localparam logic [2:0] CfgPatternTwo  = 3'd2;
  localparam logic [2:0] CfgPatternThree = 3'd3;
  localparam logic [2:0] CfgLengths     = 3'd4;
  localparam logic [2:0] CfgReportEn    = 3'd5;

  typedef struct packed {
    logic text;
    logic eof;
    logic clr;
  } mpoc_ctl_t;

endpackage

// ----- design/mpoc_lane.sv -----
// one pattern lane: window compare, overlap blocking and saturating count
module mpoc_lane #(
  parameter int MAX_PATTERN_LEN = mpoc_pkg::MaxPatternLenDef,
  parameter int COUNT_BITS      = mpoc_pkg::CountBitsDef,
  parameter int LINE_BITS       = mpoc_pkg::LineBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mpoc_pkg::mpoc_ctl_t          ctl_i,
  input  logic [8*MAX_PATTERN_LEN-1:0] win_i,
  input  logic [$clog2(MAX_PATTERN_LEN+1)-1:0] fill_i,
  input  logic [8*MAX_PATTERN_LEN-1:0] pat_i,
  input  logic [3:0]                   len_i,
  input  logic [LINE_BITS-1:0]         nl_i,
  output logic                         hit_o,
  output logic [COUNT_BITS-1:0]        count_o,
  output logic [COUNT_BITS-1:0]        count_next_o,
  output logic [LINE_BITS-1:0]         line_o
);
  import mpoc_pkg::*;

  localparam int WIDX = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam int FW   = $clog2(MAX_PATTERN_LEN + 1);

  logic [WIDX-1:0]       blk_q, blk_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                  en, eq;
  logic [FW-1:0]         inner;
  logic [WIDX-1:0]       idx;

  assign en = (len_i != 4'd0) && (len_i <= 4'(MAX_PATTERN_LEN));

  always_comb begin
    eq  = 1'b1;
    idx = '0;
    for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
      if (4'(k) < len_i) begin
        idx = WIDX'(len_i - 4'(k) - 4'd1);
        if (pat_i[8*k +: 8] != win_i[8*idx +: 8]) begin
          eq = 1'b0;
        end
      end
    end
  end

  always_comb begin
    inner = '0;
    for (int k = 1; k < MAX_PATTERN_LEN; k++) begin
      if ((4'(k) < len_i) && (win_i[8*k +: 8] == NewlineChar)) begin
        inner = inner + FW'(1);
      end
    end
  end

  assign hit_o = ctl_i.text && en && (blk_q == '0) && (4'(fill_i) >= len_i) && eq;
  assign count_o = cnt_q;
  assign count_next_o = (cnt_q == '1) ? cnt_q : cnt_q + COUNT_BITS'(1);
  assign line_o = (nl_i >= LINE_BITS'(inner)) ? nl_i - LINE_BITS'(inner) : '0;

  always_comb begin
    blk_d = blk_q;
    if (ctl_i.eof) begin
      blk_d = '0;
    end else if (ctl_i.text) begin
      if (!en) begin
        blk_d = '0;
      end else if (blk_q != '0) begin
        blk_d = blk_q - WIDX'(1);
      end else if (hit_o) begin
        blk_d = WIDX'(len_i - 4'd1);
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctl_i.clr) begin
      cnt_d = '0;
    end else if (hit_o) begin
      cnt_d = count_next_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_q <= '0;
      cnt_q <= '0;
    end else begin
      blk_q <= blk_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- design/multi_pattern_occurrence_counter_top.sv -----
// top level of the multi-pattern occurrence counter
// path: input register stage, then result buffer, then the first result on the master side
// throughput: one item per cycle while each item yields at most one result and the master side is ready;
//   an item with n results (up to NUM_PATTERNS) holds the result buffer until all n are taken
// reset: asynchronous active low, clears registers, window, line and match counts
module multi_pattern_occurrence_counter_top #(
  parameter int NUM_PATTERNS    = mpoc_pkg::NumPatternsDef,
  parameter int MAX_PATTERN_LEN = mpoc_pkg::MaxPatternLenDef,
  parameter int COUNT_BITS      = mpoc_pkg::CountBitsDef,
  parameter int LINE_BITS       = mpoc_pkg::LineBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // text_byte
  input  logic [1:0]  s_axis_tuser_i,   // mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [((2+LINE_BITS+COUNT_BITS+7)/8)*8-1:0] m_axis_tdata_o, // pattern_index, line_number, match_count
  output logic        m_axis_tuser_o,   // report_kind
  output logic        m_axis_tlast_o
);
  import mpoc_pkg::*;

  localparam int OUT_W = ((2 + LINE_BITS + COUNT_BITS + 7) / 8) * 8;
  localparam int PW    = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
  localparam int FW    = $clog2(MAX_PATTERN_LEN + 1);
  localparam int WB    = 8 * MAX_PATTERN_LEN;

  logic [WB-1:0] pat_q [NUM_PATTERNS];
  logic [15:0]   lens_q;
  logic          rep_q;

  logic       in_vld_q;
  logic [1:0] mode_q;
  logic [7:0] byte_q;

  logic [WB-1:0]        win_q, win_n;
  logic [FW-1:0]        fill_q, fill_n;
  logic [LINE_BITS-1:0] nl_q, nl_n;

  logic [NUM_PATTERNS-1:0] pend_q, pend_d;
  logic                    kind_q;
  logic [LINE_BITS-1:0]    rline_q [NUM_PATTERNS];
  logic [COUNT_BITS-1:0]   rcnt_q [NUM_PATTERNS];

  logic [NUM_PATTERNS-1:0] hit;
  logic [COUNT_BITS-1:0]   cnt_cur [NUM_PATTERNS];
  logic [COUNT_BITS-1:0]   cnt_next [NUM_PATTERNS];
  logic [LINE_BITS-1:0]    line_hit [NUM_PATTERNS];

  mpoc_ctl_t ctl;
  logic      adv, buf_free, out_last, s_acc;
  logic [1:0] sel;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PATTERNS; p++) begin
        pat_q[p] <= '0;
      end
      lens_q <= '0;
      rep_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgPatternZero, CfgPatternOne, CfgPatternTwo, CfgPatternThree: begin
          if (cfg_index_i < 3'(NUM_PATTERNS)) begin
            pat_q[cfg_index_i[PW-1:0]] <= cfg_data_i[WB-1:0];
          end
        end
        CfgLengths:  lens_q <= cfg_data_i[15:0];
        CfgReportEn: rep_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input register stage
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign adv             = in_vld_q && buf_free;
  assign s_axis_tready_o = !in_vld_q || buf_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_acc) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      mode_q <= s_axis_tuser_i;
      byte_q <= s_axis_tdata_i;
    end
  end

  always_comb begin
    ctl = '0;
    if (adv) begin
      case (mode_q)
        ModeText:  ctl.text = 1'b1;
        ModeEof:   ctl.eof  = 1'b1;
        ModeClear: ctl.clr  = 1'b1;
        default: ;
      endcase
    end
  end

  // window after the new byte
  always_comb begin
    win_n[7:0] = byte_q;
    for (int k = 1; k < MAX_PATTERN_LEN; k++) begin
      win_n[8*k +: 8] = win_q[8*(k-1) +: 8];
    end
  end

  assign fill_n = (fill_q == FW'(MAX_PATTERN_LEN)) ? fill_q : fill_q + FW'(1);
  assign nl_n   = ((byte_q == NewlineChar) && (nl_q != '1)) ? nl_q + LINE_BITS'(1) : nl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      fill_q <= '0;
      nl_q   <= '0;
    end else if (ctl.text) begin
      win_q  <= win_n;
      fill_q <= fill_n;
      nl_q   <= nl_n;
    end else if (ctl.eof) begin
      win_q  <= '0;
      fill_q <= '0;
      nl_q   <= '0;
    end
  end

  for (genvar p = 0; p < NUM_PATTERNS; p++) begin : g_lane
    mpoc_lane #(
      .MAX_PATTERN_LEN(MAX_PATTERN_LEN),
      .COUNT_BITS     (COUNT_BITS),
      .LINE_BITS      (LINE_BITS)
    ) u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .win_i       (win_n),
      .fill_i      (fill_n),
      .pat_i       (pat_q[p]),
      .len_i       (lens_q[4*p +: 4]),
      .nl_i        (nl_n),
      .hit_o       (hit[p]),
      .count_o     (cnt_cur[p]),
      .count_next_o(cnt_next[p]),
      .line_o      (line_hit[p])
    );
  end

  // result buffer
  always_comb begin
    pend_d = '0;
    if (ctl.text) begin
      pend_d = rep_q ? hit : '0;
    end else if (ctl.eof) begin
      pend_d = '1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      kind_q <= KindMatch;
    end else if (adv) begin
      pend_q <= pend_d;
      kind_q <= ctl.eof ? KindCount : KindMatch;
    end else if (m_axis_tvalid_o && m_axis_tready_i) begin
      pend_q[sel[PW-1:0]] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int p = 0; p < NUM_PATTERNS; p++) begin
        rline_q[p] <= ctl.eof ? '0 : line_hit[p];
        rcnt_q[p]  <= ctl.eof ? cnt_cur[p] : cnt_next[p];
      end
    end
  end

  always_comb begin
    sel = '0;
    for (int p = NUM_PATTERNS - 1; p >= 0; p--) begin
      if (pend_q[p]) begin
        sel = 2'(p);
      end
    end
  end

  assign out_last = ((pend_q & ~(NUM_PATTERNS'(1) << sel)) == '0);
  assign buf_free = (pend_q == '0) || (m_axis_tready_i && out_last);

  assign m_axis_tvalid_o = |pend_q;
  assign m_axis_tuser_o  = kind_q;
  assign m_axis_tlast_o  = out_last;
  assign m_axis_tdata_o  = OUT_W'({rcnt_q[sel[PW-1:0]], rline_q[sel[PW-1:0]], sel});

  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !buf_free |=> in_vld_q && $stable(byte_q) && $stable(mode_q))
    else $error("held item changed while stalled");

  a_group_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=> m_axis_tvalid_o)
    else $error("result group ended without last");

  a_eof_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.eof |=> pend_q == '1 && kind_q == KindCount)
    else $error("end of file did not load all count reports");

  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl.clr |=> cnt_cur[0] >= $past(cnt_cur[0]))
    else $error("count dropped without clear");

endmodule

// ----- dv/multi_pattern_occurrence_counter_checker.sv -----
`timescale 1ns / 100ps
// checker that predicts match and count reports and compares them with the master stream
module multi_pattern_occurrence_counter_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // text_byte
  input  logic [1:0]  s_axis_tuser_i,   // mode
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [63:0] m_axis_tdata_i,   // pattern_index, line_number, match_count
  input  logic        m_axis_tuser_i,   // report_kind
  input  logic        m_axis_tlast_i,
  output int          fail_count_o,
  output int          pending_o
);
  import mpoc_pkg::*;

  localparam int WinLen   = MaxPatternLenDef;
  localparam int NumPat   = NumPatternsDef;
  localparam int LineLsb  = 2;
  localparam int CountLsb = LineLsb + LineBitsDef;
  localparam int PadLsb   = CountLsb + CountBitsDef;
  localparam logic [CountBitsDef-1:0] CountMax = '1;
  localparam logic [LineBitsDef-1:0]  LineMax  = '1;

  typedef struct packed {
    logic                    kind;
    logic [1:0]              idx;
    logic [LineBitsDef-1:0]  line;
    logic [CountBitsDef-1:0] count;
    logic                    last;
  } occ_report_t;

  occ_report_t             expected_reports[$];
  occ_report_t             oldest_report;
  logic [63:0]             pattern_text [NumPat];
  logic [15:0]             pattern_lengths;
  logic                    report_en;
  logic [7:0]              byte_window [WinLen];
  int unsigned             window_fill;
  int unsigned             overlap_block [NumPat];
  logic [CountBitsDef-1:0] occ_counts [NumPat];
  logic [LineBitsDef-1:0]  newline_total;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic int unsigned active_length(input int p);
    int unsigned len;
    len = pattern_lengths[4*p +: 4];
    if (len == 0 || len > WinLen) return 0;
    return len;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  task automatic clear_window();
    for (int k = 0; k < WinLen; k++) byte_window[k] = 8'h00;
    window_fill = 0;
    for (int p = 0; p < NumPat; p++) overlap_block[p] = 0;
    newline_total = '0;
  endtask

  task automatic predict_reports(input logic [1:0] mode_v, input logic [7:0] byte_v);
    occ_report_t batch [NumPat];
    occ_report_t r;
    int          n;
    int unsigned len;
    int unsigned inner_nl;
    bit          hit;
    n = 0;
    case (mode_v)
      ModeText: begin
        for (int k = WinLen - 1; k > 0; k--) byte_window[k] = byte_window[k-1];
        byte_window[0] = byte_v;
        if (window_fill < WinLen) window_fill++;
        if (byte_v == NewlineChar && newline_total != LineMax) newline_total++;
        for (int p = 0; p < NumPat; p++) begin
          len = active_length(p);
          if (len == 0) begin
            overlap_block[p] = 0;
          end else if (overlap_block[p] != 0) begin
            overlap_block[p]--;
          end else if (window_fill >= len) begin
            hit = 1'b1;
            for (int k = 0; k < len; k++)
              if (pattern_text[p][8*k +: 8] != byte_window[len-1-k]) hit = 1'b0;
            if (hit) begin
              if (occ_counts[p] != CountMax) occ_counts[p]++;
              overlap_block[p] = len - 1;
              if (report_en) begin
                inner_nl = 0;
                for (int k = 1; k < len; k++)
                  if (byte_window[k] == NewlineChar) inner_nl++;
                r.kind  = KindMatch;
                r.idx   = 2'(p);
                r.line  = (newline_total >= inner_nl) ?
                          newline_total - LineBitsDef'(inner_nl) : '0;
                r.count = occ_counts[p];
                r.last  = 1'b0;
                batch[n] = r;
                n++;
              end
            end
          end
        end
      end
      ModeEof: begin
        for (int p = 0; p < NumPat; p++) begin
          r.kind  = KindCount;
          r.idx   = 2'(p);
          r.line  = '0;
          r.count = occ_counts[p];
          r.last  = 1'b0;
          batch[n] = r;
          n++;
        end
        clear_window();
      end
      ModeClear: begin
        for (int p = 0; p < NumPat; p++) occ_counts[p] = '0;
      end
      default: ;
    endcase
    if (n > 0) batch[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_reports.insert(expected_reports.size(), batch[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NumPat; p++) begin
        pattern_text[p] = '0;
        occ_counts[p]   = '0;
      end
      pattern_lengths = '0;
      report_en       = 1'b0;
      clear_window();
      expected_reports.delete();
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgPatternZero, CfgPatternOne, CfgPatternTwo, CfgPatternThree:
            pattern_text[cfg_index_i[1:0]] = cfg_data_i;
          CfgLengths:  pattern_lengths = cfg_data_i[15:0];
          CfgReportEn: report_en = cfg_data_i[0];
          default: ;
        endcase
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected report: kind %0d, pattern %0d, count %0d",
                 m_axis_tuser_i, m_axis_tdata_i[1:0], m_axis_tdata_i[PadLsb-1:CountLsb]);
          fail_count_o++;
        end else begin
          oldest_report = expected_reports.pop_front();
          check_field("report_kind", oldest_report.kind, m_axis_tuser_i);
          check_field("pattern_index", oldest_report.idx, m_axis_tdata_i[1:0]);
          check_field("line_number", oldest_report.line, m_axis_tdata_i[CountLsb-1:LineLsb]);
          check_field("match_count", oldest_report.count, m_axis_tdata_i[PadLsb-1:CountLsb]);
          check_field("last_of_run", oldest_report.last, m_axis_tlast_i);
          check_field("tdata padding", 64'd0, m_axis_tdata_i[63:PadLsb]);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        predict_reports(s_axis_tuser_i, s_axis_tdata_i);
      pending_o = expected_reports.size();
    end
  end

endmodule

// ----- dv/multi_pattern_occurrence_counter_top_tb.sv -----
`timescale 1ns / 100ps
// testbench top: stimulus, flow control and verdict for the multi-pattern occurrence counter
module multi_pattern_occurrence_counter_top_tb;
  import mpoc_pkg::*;

  localparam logic [1:0] ModeIgnored    = 2'd3;
  localparam logic [2:0] CfgUnusedLow   = 3'd6;
  localparam logic [2:0] CfgUnusedHigh  = 3'd7;
  localparam int         StallCycles    = 300;
  localparam int         SettleCycles   = 4;

  logic        clk_i;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // text_byte
  logic [1:0]  s_axis_tuser;   // mode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // pattern_index, line_number, match_count
  logic        m_axis_tuser;   // report_kind
  logic        m_axis_tlast;

  int          failures;
  int          pending_reports;
  int          src_idle_pct;
  int          dst_idle_pct;
  bit          stall_request;

  logic [63:0] stim_pattern [4];
  logic [15:0] stim_lengths;
  logic        stim_report;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  multi_pattern_occurrence_counter_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  multi_pattern_occurrence_counter_checker report_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .m_axis_tlast_i  (m_axis_tlast),
    .fail_count_o    (failures),
    .pending_o       (pending_reports)
  );

  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return "a";
    if (r < 6) return "b";
    if (r < 7) return NewlineChar;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_item(input logic [1:0] mode_v, input logic [7:0] byte_v);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode_v;
    s_axis_tdata  <= byte_v;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic push_text(input string text_v);
    for (int i = 0; i < text_v.len(); i++) push_item(ModeText, text_v[i]);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_reports != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic put_register(input logic [2:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
  endtask

  task automatic write_settings(input bit with_unused);
    wait_idle();
    for (int p = 0; p < 4; p++) put_register(CfgPatternZero + 3'(p), stim_pattern[p]);
    put_register(CfgLengths, {48'($urandom), stim_lengths});
    put_register(CfgReportEn, {63'({$urandom, $urandom}), stim_report});
    if (with_unused) begin
      put_register(CfgUnusedLow, {$urandom, $urandom});
      put_register(CfgUnusedHigh, {$urandom, $urandom});
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic randomize_settings();
    for (int p = 0; p < 4; p++) begin
      for (int k = 0; k < 8; k++) stim_pattern[p][8*k +: 8] = pick_text_byte();
      stim_lengths[4*p +: 4] = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                           : 4'($urandom_range(1, 4));
    end
    stim_report = ($urandom_range(0, 3) != 0);
  endtask

  task automatic run_random_text(input int item_goal);
    int made;
    int r;
    int p;
    int len;
    made = 0;
    while (made < item_goal) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        p   = $urandom_range(0, 3);
        len = stim_lengths[4*p +: 4];
        if (len == 0 || len > 8) len = 3;
        for (int k = 0; k < len; k++) push_item(ModeText, stim_pattern[p][8*k +: 8]);
        made += len;
      end else if (r < 85) begin
        push_item(ModeText, pick_text_byte());
        made++;
      end else if (r < 91) begin
        push_item(ModeEof, 8'($urandom));
        made++;
      end else if (r < 94) begin
        push_item(ModeClear, 8'($urandom));
        made++;
      end else if (r < 97) begin
        push_item(ModeIgnored, 8'($urandom));
      end else begin
        push_item(ModeText, 8'($urandom));
        made++;
      end
    end
    push_item(ModeEof, 8'($urandom));
  endtask

  initial begin
    m_axis_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk_i);
      if (stall_request) begin
        stall_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (StallCycles) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
      end
    end
  end

  initial begin
    #2_400_000;
    $display("FAIL multi_pattern_occurrence_counter_top");
    $finish;
  end

  initial begin
    rst_n         <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ModeText;
    stall_request = 1'b0;
    src_idle_pct  = 25;
    dst_idle_pct  = 81;
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;

    // restart after partial match, overlap, inner newline, full length with extreme bytes
    stim_pattern[0] = 64'h0000_0000_0062_6161;
    stim_pattern[1] = 64'h0000_0000_0000_6161;
    stim_pattern[2] = 64'h0000_0000_0079_0A78;
    stim_pattern[3] = 64'hFF00_FF00_FF00_FF00;
    stim_lengths    = 16'h8323;
    stim_report     = 1'b1;
    write_settings(1'b0);
    push_item(ModeText, NewlineChar);
    push_text("aaab");
    push_text("x\ny");
    for (int i = 0; i < 4; i++) begin
      push_item(ModeText, 8'h00);
      push_item(ModeText, 8'hFF);
    end
    push_item(ModeIgnored, 8'hFF);
    push_item(ModeEof, 8'h00);
    push_text("aa");
    push_item(ModeClear, 8'hFF);
    push_item(ModeEof, 8'hFF);

    for (int ph = 1; ph <= 7; ph++) begin
      case (ph)
        2: begin
          stim_pattern[0] = {$urandom, $urandom};
          stim_pattern[1] = {$urandom, $urandom};
          stim_pattern[2] = '1;
          stim_pattern[3] = '0;
          stim_lengths    = 16'h8888;
          stim_report     = 1'b1;
        end
        3: begin
          randomize_settings();
          stim_lengths = 16'h0000;
          stim_report  = 1'b0;
        end
        4: begin
          randomize_settings();
          stim_lengths = 16'hFFFF;
          stim_report  = 1'b1;
        end
        default: randomize_settings();
      endcase
      write_settings(ph == 4);
      if (ph == 4) begin
        src_idle_pct = 81;
        dst_idle_pct = 25;
      end else if (ph == 6) begin
        src_idle_pct = 0;
        dst_idle_pct = 0;
        stall_request = 1'b1;
        for (int i = 0; i < 12; i++)
          push_item(i % 3 == 0 ? ModeText : ModeEof, pick_text_byte());
      end
      run_random_text((ph == 3 || ph == 4) ? 12 : 30);
    end

    wait_idle();
    if (failures == 0) begin
      $display("PASS multi_pattern_occurrence_counter_top");
    end else begin
      $display("FAIL multi_pattern_occurrence_counter_top");
    end
    $finish;
  end

endmodule
